// ===== src/nmt_pkg.sv =====
// ----------------------------------------------------------------------------
// nmt_pkg: shared types and constants of the nat mapping table
// Action and status codes, field widths, table entry and result records.
// ----------------------------------------------------------------------------
package nmt_pkg;

    // default table depth
    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    // field widths
    localparam int unsigned IP_W     = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SERIAL_W = 32;
    localparam int unsigned TMO_W    = 16;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // port allocation
    localparam logic [PORT_W-1:0] PORT_BASE = 16'd1024;
    localparam logic [PORT_W:0]   PORT_SPAN = 17'd64500;

    // register reset values
    localparam logic [TMO_W-1:0] ICMP_TIMEOUT_RST = 16'd60;

    // saturation limit of the removal count
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_LOOKUP_INT = 2'd0,
        ACT_LOOKUP_EXT = 2'd1,
        ACT_INSERT     = 2'd2,
        ACT_TICK       = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_FULL        = 2'd2,
        ST_BAD_OPERAND = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ICMP = 1'b0,
        KIND_TCP  = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXTERNAL_IP  = 1'd0,
        CFG_ICMP_TIMEOUT = 1'd1
    } t_cfg_idx;

    // one stored mapping
    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [IP_W-1:0]     int_ip;
        logic [PORT_W-1:0]   int_port;
        logic [IP_W-1:0]     ext_ip;
        logic [PORT_W-1:0]   ext_port;
        logic [TIME_W-1:0]   created;
        logic [SERIAL_W-1:0] serial;
    } t_entry;

    // one result record
    typedef struct packed {
        logic [1:0]        status;
        logic              kind;
        logic [IP_W-1:0]   int_ip;
        logic [PORT_W-1:0] int_port;
        logic [IP_W-1:0]   ext_ip;
        logic [PORT_W-1:0] ext_port;
        logic [TIME_W-1:0] created;
        logic [CNT_W-1:0]  removed;
    } t_rsp;

endpackage

// ===== src/nmt_req_if.sv =====
// ----------------------------------------------------------------------------
// nmt_req_if: command channel of the nat mapping table
// Valid/ready channel carrying one command per transfer.
// ----------------------------------------------------------------------------
interface nmt_req_if;
    import nmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic              mapping_kind;
    logic [IP_W-1:0]   internal_ip;
    logic [PORT_W-1:0] internal_port;
    logic [PORT_W-1:0] external_port;

    modport source (
        output valid, action, mapping_kind, internal_ip, internal_port, external_port,
        input  ready
    );

    modport sink (
        input  valid, action, mapping_kind, internal_ip, internal_port, external_port,
        output ready
    );
endinterface

// ===== src/nmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nmt_rsp_if: result channel of the nat mapping table
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface nmt_rsp_if;
    import nmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              result_kind;
    logic [IP_W-1:0]   result_internal_ip;
    logic [PORT_W-1:0] result_internal_port;
    logic [IP_W-1:0]   result_external_ip;
    logic [PORT_W-1:0] result_external_port;
    logic [TIME_W-1:0] result_time;
    logic [CNT_W-1:0]  removed_count;

    modport source (
        output valid, status, result_kind, result_internal_ip, result_internal_port,
               result_external_ip, result_external_port, result_time, removed_count,
        input  ready
    );

    modport sink (
        input  valid, status, result_kind, result_internal_ip, result_internal_port,
               result_external_ip, result_external_port, result_time, removed_count,
        output ready
    );
endinterface

// ===== src/nat_mapping_table_unit.sv =====
// ----------------------------------------------------------------------------
// nat_mapping_table_unit: nat port translation table
// Flow: a command is taken, then the table is walked one entry per cycle through
// one shared compare unit; an insert then writes its slot, and an insert with a
// zero operand skips the walk. The result is staged and then handed to the output
// register; the next command is taken once it is handed over, later while a result waits.
// Reset: a clearing pass over every entry empties the memory; no command
// is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
module nat_mapping_table_unit #(
    parameter int unsigned TABLE_ENTRIES = nmt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    nmt_req_if.sink                             i_req,
    nmt_rsp_if.source                           o_rsp,
    input  logic                                i_cfg_we,
    input  logic [nmt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [nmt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import nmt_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W:0] END_IDX  = (IDX_W+1)'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_INSERT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    // entry memory
    t_entry mem [TABLE_ENTRIES];
    t_entry r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // configuration and global counters
    logic [IP_W-1:0]     r_ext_ip;
    logic [TMO_W-1:0]    r_icmp_tmo;
    logic [TIME_W-1:0]   r_secs,    n_secs;
    logic [PORT_W-1:0]   r_port_cnt, n_port_cnt;
    logic [SERIAL_W-1:0] r_ins_cnt, n_ins_cnt;

    // sequencer
    t_state            r_state, n_state;
    logic [IDX_W:0]    r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;

    // captured command
    logic [1:0]        r_act;
    logic              r_kind;
    logic [IP_W-1:0]   r_ip;
    logic [PORT_W-1:0] r_iport;
    logic [PORT_W-1:0] r_eport;

    // scan results
    logic              r_best_vld, n_best_vld;
    logic [SERIAL_W-1:0] r_best_age, n_best_age;
    t_entry            r_best, n_best;
    logic              r_free_vld, n_free_vld;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [CNT_W-1:0]  r_rm_cnt, n_rm_cnt;

    // staged and output results
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_vld, n_out_vld;

    // shared unit
    logic [TIME_W-1:0] sub_a, sub_b, diff;
    logic [TIME_W-1:0] cmp_l, cmp_r;
    logic              lt;

    logic              req_xfer;
    logic              issue;
    logic              hit;
    logic [PORT_W:0]   port_inc;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;
    assign issue       = (r_idx < END_IDX);
    assign rd_addr     = r_idx[IDX_W-1:0];

    // shared subtract and compare: entry age against best or timeout
    always_comb begin
        if (r_act == ACT_TICK) begin
            sub_a = r_secs;
            sub_b = r_rd_data.created;
        end else begin
            sub_a = r_ins_cnt;
            sub_b = r_rd_data.serial;
        end
        diff = sub_a - sub_b;
        if (r_act == ACT_TICK) begin
            cmp_l = {{(TIME_W-TMO_W){1'b0}}, r_icmp_tmo};
            cmp_r = diff;
        end else begin
            cmp_l = diff;
            cmp_r = r_best_age;
        end
        lt = (cmp_l < cmp_r);
    end

    // key match for lookups
    always_comb begin
        if (r_act == ACT_LOOKUP_EXT) begin
            hit = (r_rd_data.ext_port == r_eport);
        end else begin
            hit = (r_rd_data.int_ip == r_ip) && (r_rd_data.int_port == r_iport);
        end
        hit = hit && r_rd_data.valid && (r_rd_data.kind == r_kind);
    end

    assign port_inc = {1'b0, r_port_cnt} + 1'b1;

    // sequencer next state and memory write port
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_chk_idx  = r_chk_idx;
        n_secs     = r_secs;
        n_port_cnt = r_port_cnt;
        n_ins_cnt  = r_ins_cnt;
        n_best_vld = r_best_vld;
        n_best_age = r_best_age;
        n_best     = r_best;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_rm_cnt   = r_rm_cnt;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        wr_en      = 1'b0;
        wr_addr    = r_idx[IDX_W-1:0];
        wr_data    = '0;

        // output register drains independently
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_xfer) begin
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_best_vld = 1'b0;
                    n_best_age = '0;
                    n_free_vld = 1'b0;
                    n_rm_cnt   = '0;
                    n_res      = '0;
                    if (i_req.action == ACT_INSERT &&
                        (i_req.internal_ip == '0 || i_req.internal_port == '0)) begin
                        n_res.status = ST_BAD_OPERAND;
                        n_state      = S_DONE;
                    end else begin
                        if (i_req.action == ACT_TICK) begin
                            n_secs = r_secs + 1'b1;
                        end
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle
                n_pend    = issue;
                n_chk_idx = r_idx[IDX_W-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                // evaluate the entry read in the previous cycle
                if (r_pend) begin
                    case (r_act)
                        ACT_LOOKUP_INT, ACT_LOOKUP_EXT: begin
                            if (hit && (!r_best_vld || lt)) begin
                                n_best_vld = 1'b1;
                                n_best_age = diff;
                                n_best     = r_rd_data;
                            end
                        end
                        ACT_INSERT: begin
                            if (!r_rd_data.valid && !r_free_vld) begin
                                n_free_vld = 1'b1;
                                n_free_idx = r_chk_idx;
                            end
                        end
                        ACT_TICK: begin
                            if (r_rd_data.valid && r_rd_data.kind == KIND_ICMP && lt) begin
                                wr_en         = 1'b1;
                                wr_addr       = r_chk_idx;
                                wr_data       = r_rd_data;
                                wr_data.valid = 1'b0;
                                if (r_rm_cnt != CNT_MAX) begin
                                    n_rm_cnt = r_rm_cnt + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // walk complete
                if (!issue && !r_pend) begin
                    case (r_act)
                        ACT_LOOKUP_INT, ACT_LOOKUP_EXT: begin
                            if (r_best_vld) begin
                                n_res.status   = ST_OK;
                                n_res.kind     = r_best.kind;
                                n_res.int_ip   = r_best.int_ip;
                                n_res.int_port = r_best.int_port;
                                n_res.ext_ip   = r_best.ext_ip;
                                n_res.ext_port = r_best.ext_port;
                                n_res.created  = r_best.created;
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                            n_state = S_DONE;
                        end
                        ACT_INSERT: begin
                            if (r_free_vld) begin
                                n_state = S_INSERT;
                            end else begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_res.status  = ST_OK;
                            n_res.removed = r_rm_cnt;
                            n_state       = S_DONE;
                        end
                    endcase
                end
            end
            S_INSERT: begin
                // store the new mapping in the lowest free slot
                wr_en            = 1'b1;
                wr_addr          = r_free_idx;
                wr_data.valid    = 1'b1;
                wr_data.kind     = r_kind;
                wr_data.int_ip   = r_ip;
                wr_data.int_port = r_iport;
                wr_data.ext_ip   = r_ext_ip;
                wr_data.ext_port = PORT_BASE + r_port_cnt;
                wr_data.created  = r_secs;
                wr_data.serial   = r_ins_cnt;
                n_ins_cnt        = r_ins_cnt + 1'b1;
                n_port_cnt       = (port_inc >= PORT_SPAN) ? '0 : port_inc[PORT_W-1:0];
                n_res.status     = ST_OK;
                n_res.kind       = r_kind;
                n_res.int_ip     = r_ip;
                n_res.int_port   = r_iport;
                n_res.ext_ip     = r_ext_ip;
                n_res.ext_port   = PORT_BASE + r_port_cnt;
                n_res.created    = r_secs;
                n_res.removed    = '0;
                n_state          = S_DONE;
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_secs     <= '0;
            r_port_cnt <= '0;
            r_ins_cnt  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_secs     <= n_secs;
            r_port_cnt <= n_port_cnt;
            r_ins_cnt  <= n_ins_cnt;
            r_out_vld  <= n_out_vld;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_ip   <= '0;
            r_icmp_tmo <= ICMP_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXTERNAL_IP:  r_ext_ip   <= i_cfg_data[IP_W-1:0];
                CFG_ICMP_TIMEOUT: r_icmp_tmo <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_act   <= i_req.action;
            r_kind  <= i_req.mapping_kind;
            r_ip    <= i_req.internal_ip;
            r_iport <= i_req.internal_port;
            r_eport <= i_req.external_port;
        end
        r_chk_idx  <= n_chk_idx;
        r_best_vld <= n_best_vld;
        r_best_age <= n_best_age;
        r_best     <= n_best;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_rm_cnt   <= n_rm_cnt;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // result channel
    assign o_rsp.valid                = r_out_vld;
    assign o_rsp.status               = r_out.status;
    assign o_rsp.result_kind          = r_out.kind;
    assign o_rsp.result_internal_ip   = r_out.int_ip;
    assign o_rsp.result_internal_port = r_out.int_port;
    assign o_rsp.result_external_ip   = r_out.ext_ip;
    assign o_rsp.result_external_port = r_out.ext_port;
    assign o_rsp.result_time          = r_out.created;
    assign o_rsp.removed_count        = r_out.removed;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nat mapping table unit
// Commands go in over a valid/ready channel, each result is checked field by
// field against a cycle-free model of the table kept in the bench. A directed
// opening covers empty-table lookups, zero operands, duplicate keys, kind
// mismatches, aging and slot reuse. Random phases follow under several
// register settings and idle patterns, with a table fill to the full state.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nmt_pkg::*;

    localparam int unsigned TBL_N      = TABLE_ENTRIES_DEF;
    localparam int unsigned SETTLE_CYC = TBL_N + 8;
    localparam int unsigned LONG_STALL = 600;
    localparam int unsigned POOL_N     = 6;

    // one command as presented on the request channel
    typedef struct packed {
        t_action           action;
        t_kind             kind;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] iport;
        logic [PORT_W-1:0] eport;
    } t_nat_cmd;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // bench-side drive registers
    t_nat_cmd                cur_cmd   = '0;
    logic                    req_valid = 1'b0;
    logic                    rsp_ready = 1'b0;
    logic                    cfg_we    = 1'b0;
    t_cfg_idx                cfg_idx   = CFG_EXTERNAL_IP;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    nmt_req_if req_if ();
    nmt_rsp_if rsp_if ();

    assign req_if.valid         = req_valid;
    assign req_if.action        = cur_cmd.action;
    assign req_if.mapping_kind  = cur_cmd.kind;
    assign req_if.internal_ip   = cur_cmd.ip;
    assign req_if.internal_port = cur_cmd.iport;
    assign req_if.external_port = cur_cmd.eport;
    assign rsp_if.ready         = rsp_ready;

    nat_mapping_table_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // stimulus backlog and results still owed by the block
    t_nat_cmd cmd_backlog [$];
    t_rsp     due_answers [$];

    // idle pattern and long receiver hold-off
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 76;
    logic        stall_go      = 1'b0;
    int unsigned stall_cnt     = 0;

    // transfer bookkeeping between monitor and driver
    int unsigned req_xfers = 0;
    int unsigned req_seen  = 0;
    int unsigned bad_fields = 0;
    t_nat_cmd    next_cmd;
    t_rsp        want;

    // shadow registers
    logic [IP_W-1:0]  shadow_ext_ip = '0;
    logic [TMO_W-1:0] shadow_tmo    = ICMP_TIMEOUT_RST;

    // bench copy of the translation table
    t_entry              nat_tbl [TBL_N];
    logic [TIME_W-1:0]   clock_sec;
    logic [PORT_W-1:0]   port_ctr;
    logic [SERIAL_W-1:0] ins_serial;

    // stimulus pools so that lookups hit stored keys
    logic [IP_W-1:0]   ip_pool   [POOL_N];
    logic [PORT_W-1:0] port_pool [POOL_N];
    int unsigned       inserts_drawn = 0;

    // result view of one stored mapping
    function automatic t_rsp entry_view(t_entry e);
        t_rsp r;
        r          = '0;
        r.status   = ST_OK;
        r.kind     = e.kind;
        r.int_ip   = e.int_ip;
        r.int_port = e.int_port;
        r.ext_ip   = e.ext_ip;
        r.ext_port = e.ext_port;
        r.created  = e.created;
        return r;
    endfunction

    // apply one command to the bench table and return the block's answer
    function automatic t_rsp apply_nat_cmd(t_nat_cmd c);
        t_rsp                r;
        int                  hit;
        int                  i;
        logic [SERIAL_W-1:0] age;
        logic [SERIAL_W-1:0] best_age;
        logic [TIME_W-1:0]   aged;
        logic [PORT_W:0]     nxt;
        logic                match;
        int unsigned         swept;
        r        = '0;
        hit      = -1;
        best_age = '0;
        swept    = 0;
        case (c.action)
            ACT_LOOKUP_INT, ACT_LOOKUP_EXT: begin
                // newest valid match wins, lowest slot on a tie
                for (i = 0; i < TBL_N; i++) begin
                    if (c.action == ACT_LOOKUP_EXT)
                        match = nat_tbl[i].ext_port == c.eport;
                    else
                        match = nat_tbl[i].int_ip == c.ip && nat_tbl[i].int_port == c.iport;
                    if (nat_tbl[i].valid && nat_tbl[i].kind == c.kind && match) begin
                        age = ins_serial - nat_tbl[i].serial;
                        if (hit < 0 || age < best_age) begin
                            hit      = i;
                            best_age = age;
                        end
                    end
                end
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r = entry_view(nat_tbl[hit]);
            end
            ACT_INSERT: begin
                if (c.ip == '0 || c.iport == '0) begin
                    r.status = ST_BAD_OPERAND;
                end else begin
                    // lowest free slot
                    for (i = TBL_N - 1; i >= 0; i--)
                        if (!nat_tbl[i].valid)
                            hit = i;
                    if (hit < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        nat_tbl[hit].valid    = 1'b1;
                        nat_tbl[hit].kind     = c.kind;
                        nat_tbl[hit].int_ip   = c.ip;
                        nat_tbl[hit].int_port = c.iport;
                        nat_tbl[hit].ext_ip   = shadow_ext_ip;
                        nat_tbl[hit].ext_port = PORT_BASE + port_ctr;
                        nat_tbl[hit].created  = clock_sec;
                        nat_tbl[hit].serial   = ins_serial;
                        ins_serial = ins_serial + 1'b1;
                        nxt = {1'b0, port_ctr} + 1'b1;
                        port_ctr = (nxt >= PORT_SPAN) ? '0 : nxt[PORT_W-1:0];
                        r = entry_view(nat_tbl[hit]);
                    end
                end
            end
            default: begin
                // one-second tick, then sweep of aged icmp mappings
                clock_sec = clock_sec + 1'b1;
                for (i = 0; i < TBL_N; i++) begin
                    aged = clock_sec - nat_tbl[i].created;
                    if (nat_tbl[i].valid && nat_tbl[i].kind == KIND_ICMP &&
                        shadow_tmo < aged) begin
                        nat_tbl[i].valid = 1'b0;
                        swept++;
                    end
                end
                r.status  = ST_OK;
                r.removed = (swept > CNT_MAX) ? CNT_MAX : CNT_W'(swept);
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h",
                     $time, name, exp_v, got_v);
            bad_fields++;
        end
    endtask

    // monitor: request transfers update the table, result transfers are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TBL_N; k++)
                nat_tbl[k] = '0;
            clock_sec  = '0;
            port_ctr   = '0;
            ins_serial = '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                due_answers.push_back(apply_nat_cmd(cur_cmd));
                req_xfers++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_answers.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual status %0d",
                             $time, rsp_if.status);
                    bad_fields++;
                end else begin
                    want = due_answers.pop_front();
                    check_field("status", want.status, rsp_if.status);
                    check_field("result_kind", want.kind, rsp_if.result_kind);
                    check_field("result_internal_ip", want.int_ip, rsp_if.result_internal_ip);
                    check_field("result_internal_port", want.int_port,
                                rsp_if.result_internal_port);
                    check_field("result_external_ip", want.ext_ip, rsp_if.result_external_ip);
                    check_field("result_external_port", want.ext_port,
                                rsp_if.result_external_port);
                    check_field("result_time", want.created, rsp_if.result_time);
                    check_field("removed_count", want.removed, rsp_if.removed_count);
                end
            end
        end
    end

    // command driver: next item after each transfer, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_valid || req_xfers != req_seen)) begin
            req_seen = req_xfers;
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = cmd_backlog.pop_front();
                cur_cmd   <= next_cmd;
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result receiver: one long hold-off, otherwise random stalls
    always @(negedge i_clk) begin
        if (stall_go && stall_cnt < LONG_STALL) begin
            stall_cnt++;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_nat_cmd mk_cmd(t_action a, t_kind k, logic [IP_W-1:0] ip,
                                        logic [PORT_W-1:0] iport, logic [PORT_W-1:0] eport);
        t_nat_cmd c;
        c.action = a;
        c.kind   = k;
        c.ip     = ip;
        c.iport  = iport;
        c.eport  = eport;
        return c;
    endfunction

    // random command: mostly pooled keys, some zero operands and pure noise
    function automatic t_nat_cmd draw_cmd();
        t_nat_cmd    c;
        int unsigned pick;
        pick     = $urandom_range(99);
        c.action = ACT_LOOKUP_INT;
        c.kind   = ($urandom_range(5) == 0) ? KIND_TCP : KIND_ICMP;
        c.ip     = ip_pool[$urandom_range(POOL_N - 1)];
        c.iport  = port_pool[$urandom_range(POOL_N - 1)];
        c.eport  = PORT_BASE + PORT_W'($urandom_range(inserts_drawn + 3));
        if (pick < 5) begin
            c.action = t_action'($urandom_range(3));
            c.kind   = t_kind'($urandom_range(1));
            c.ip     = $urandom;
            c.iport  = PORT_W'($urandom);
            c.eport  = PORT_W'($urandom);
        end else if (pick < 15) begin
            c.action = ACT_TICK;
        end else if (pick < 50) begin
            c.action = ACT_INSERT;
            c.kind   = ($urandom_range(24) == 0) ? KIND_TCP : KIND_ICMP;
            inserts_drawn++;
            case ($urandom_range(39))
                0: c.ip = '0;
                1: c.iport = '0;
                default: ;
            endcase
        end else if (pick < 80) begin
            if ($urandom_range(9) == 0)
                c.ip = $urandom;
        end else begin
            c.action = ACT_LOOKUP_EXT;
        end
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_EXTERNAL_IP:  shadow_ext_ip = data;
            CFG_ICMP_TIMEOUT: shadow_tmo    = data[TMO_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // hold off new commands until every result is back and the block is quiet
    task automatic settle();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || req_valid || due_answers.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic push_random(int unsigned n);
        repeat (n) cmd_backlog.push_back(draw_cmd());
    endtask

    // sequence of phases
    initial begin
        int i;
        for (i = 0; i < POOL_N; i++) begin
            ip_pool[i]   = $urandom | 32'h1;
            port_pool[i] = PORT_W'($urandom) | 16'h1;
        end
        ip_pool[0]   = '1;
        port_pool[0] = '1;
        ip_pool[1]   = 32'h1;
        port_pool[1] = 16'h1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, zero operands, duplicate keys under reset settings
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_ICMP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_TCP, '0, '0, '1));
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_ICMP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_ICMP, '0, 16'd5, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_TCP, 32'h1, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_TCP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_ICMP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_TCP, '1, '1, '1));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_TCP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_ICMP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_TCP, '0, '0, 16'd1024));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_ICMP, '1, '1, 16'd1024));
        settle();

        // short timeout so aging shows within a few ticks
        write_reg(CFG_EXTERNAL_IP, 32'hA5C3_0F01);
        write_reg(CFG_ICMP_TIMEOUT, 32'd1);
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_ICMP, 32'h1, 16'h1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_TCP, 32'h1, 16'h1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_ICMP, '0, '0, 16'd1025));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_TCP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_ICMP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_ICMP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_ICMP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_INT, KIND_TCP, '1, '1, '0));
        cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_ICMP, 32'h8000_0000, 16'h8000, '0));
        cmd_backlog.push_back(mk_cmd(ACT_LOOKUP_EXT, KIND_ICMP, '0, '0, 16'd1028));
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_TCP, '1, '1, '1));
        inserts_drawn = 5;
        settle();

        // sender busy, receiver slow, one long hold-off at the start
        write_reg(CFG_EXTERNAL_IP, $urandom);
        write_reg(CFG_ICMP_TIMEOUT, 32'd5);
        stall_go = 1'b1;
        push_random(650);
        settle();

        // sender slow, receiver busy, every icmp mapping dies on the next tick
        send_idle_pct = 76;
        recv_idle_pct = 17;
        write_reg(CFG_EXTERNAL_IP, '1);
        write_reg(CFG_ICMP_TIMEOUT, 32'd0);
        push_random(500);
        settle();

        // no idling from here; fill the table with nothing aging out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_EXTERNAL_IP, $urandom);
        write_reg(CFG_ICMP_TIMEOUT, 32'hFFFF);
        repeat (70)
            cmd_backlog.push_back(mk_cmd(ACT_INSERT, KIND_ICMP,
                                         ip_pool[$urandom_range(POOL_N - 1)],
                                         PORT_W'($urandom_range(65535, 1)), '0));
        inserts_drawn += 70;
        push_random(10);
        settle();

        // zero timeout sweeps every icmp mapping of the full table in one tick
        write_reg(CFG_EXTERNAL_IP, '0);
        write_reg(CFG_ICMP_TIMEOUT, 32'd0);
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_ICMP, '0, '0, '0));
        cmd_backlog.push_back(mk_cmd(ACT_TICK, KIND_ICMP, '0, '0, '0));
        push_random(15);
        settle();

        // longer lifetime so the table runs full again by itself
        write_reg(CFG_ICMP_TIMEOUT, 32'd9);
        push_random(600);
        settle();

        if (bad_fields == 0 && due_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
